/* design/qpd_pkg.sv */
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, constants and the hex digit lookup for the quoted-printable
// decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

   localparam int QPD_QUEUE_DEPTH    = 4;
   localparam int QPD_MAX_OUT        = 3;
   localparam int QPD_COUNT_WIDTH    = 2;
   localparam int QPD_CSR_ADDR_WIDTH = 3;

   localparam logic [7:0] QPD_EQUALS      = 8'h3D;
   localparam logic [3:0] QPD_HIGH_NIBBLE = 4'hF;

   // register index of accept_lowercase_hex
   localparam logic QPD_CSR_IDX_LOWERCASE = 1'b0;

   typedef enum logic [2:0] {
      QPD_IDLE  = 3'b001,
      QPD_EQ    = 3'b010,
      QPD_DIGIT = 3'b100
   } qpd_phase_type;

   typedef struct packed {
      logic [QPD_MAX_OUT-1:0][7:0] data;
      logic [QPD_COUNT_WIDTH-1:0]  count;
      logic                        last;
   } qpd_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qpd_queue_status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } qpd_hex_type;

   function automatic qpd_hex_type qpd_hex(input logic [7:0] c, input logic lower);
      qpd_hex_type r;
      r.valid = 1'b1;
      r.value = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = c[3:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = c[3:0] + 4'd9;
      end else if (lower && c >= 8'h61 && c <= 8'h66) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.valid = 1'b0;
         r.value = QPD_HIGH_NIBBLE;
      end
      return r;
   endfunction

endpackage

/* design/qpd_front.sv */
// ----------------------------------------------------------------------------
// qpd_front
// Tracks the escape state and turns each accepted byte into a command of
// zero to three output bytes.
// ----------------------------------------------------------------------------
module qpd_front
   import qpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept_i,
   input  logic [7:0]  in_byte_i,
   input  logic        in_last_i,
   input  logic        lower_i,
   output logic        push_o,
   output qpd_cmd_type cmd_o
);

   qpd_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   qpd_hex_type   digit, hi;
   logic          plain_opens;

   always_comb begin
      digit       = qpd_hex(in_byte_i, lower_i);
      hi          = qpd_hex(held_ff, lower_i);
      plain_opens = (in_byte_i == QPD_EQUALS) && !in_last_i;
      phase_in    = phase_ff;
      held_in     = held_ff;
      cmd_o.data  = '0;
      cmd_o.count = '0;
      cmd_o.last  = in_last_i;
      case (phase_ff)
         QPD_EQ: begin
            if (digit.valid && !in_last_i) begin
               held_in  = in_byte_i;
               phase_in = QPD_DIGIT;
            end else begin
               cmd_o.data[0] = QPD_EQUALS;
               if (plain_opens) begin
                  cmd_o.count = 2'd1;
                  phase_in    = QPD_EQ;
               end else begin
                  cmd_o.data[1] = in_byte_i;
                  cmd_o.count   = 2'd2;
                  phase_in      = QPD_IDLE;
               end
            end
         end
         QPD_DIGIT: begin
            if (digit.valid) begin
               cmd_o.data[0] = {hi.valid ? hi.value : QPD_HIGH_NIBBLE, digit.value};
               cmd_o.count   = 2'd1;
               phase_in      = QPD_IDLE;
            end else begin
               cmd_o.data[0] = QPD_EQUALS;
               cmd_o.data[1] = held_ff;
               if (plain_opens) begin
                  cmd_o.count = 2'd2;
                  phase_in    = QPD_EQ;
               end else begin
                  cmd_o.data[2] = in_byte_i;
                  cmd_o.count   = 2'd3;
                  phase_in      = QPD_IDLE;
               end
            end
         end
         default: begin
            if (plain_opens) begin
               phase_in = QPD_EQ;
            end else begin
               cmd_o.data[0] = in_byte_i;
               cmd_o.count   = 2'd1;
               phase_in      = QPD_IDLE;
            end
         end
      endcase
      if (in_last_i) begin
         phase_in = QPD_IDLE;
      end
   end

   assign push_o = accept_i && (cmd_o.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= QPD_IDLE;
      end else if (accept_i) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_i) begin
         held_ff <= held_in;
      end
   end

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (accept_i && in_last_i) |=> (phase_ff == QPD_IDLE))
      else $error("escape still pending after end of string");

   a_last_always_emits: assert property (@(posedge clock) disable iff (reset)
      (accept_i && in_last_i) |-> push_o)
      else $error("end of string produced no transfer");

endmodule

/* design/qpd_queue.sv */
// ----------------------------------------------------------------------------
// qpd_queue
// Short command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module qpd_queue
   import qpd_pkg::*;
#(
   parameter int DEPTH = QPD_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_i,
   input  qpd_cmd_type          cmd_i,
   input  logic                 pop_i,
   output qpd_cmd_type          head_o,
   output qpd_queue_status_type status_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qpd_cmd_type      entries [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status_o.full  = (count_ff == CNT_W'(DEPTH));
   assign status_o.empty = (count_ff == '0);
   assign do_push        = push_i && !status_o.full;
   assign do_pop         = pop_i && !status_o.empty;
   assign head_o         = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= cmd_i;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_i |-> !status_o.full)
      else $error("command pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

/* design/qpd_back.sv */
// ----------------------------------------------------------------------------
// qpd_back
// Walks the bytes of the oldest command and presents them one at a time on
// the result channel.
// ----------------------------------------------------------------------------
module qpd_back
   import qpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  qpd_cmd_type          head_i,
   input  qpd_queue_status_type status_i,
   input  logic                 pop,
   output logic                 empty,
   output logic [7:0]           out_byte_o,
   output logic                 out_last_o,
   output logic                 release_o
);

   logic [QPD_COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic                       final_byte;
   logic                       take;

   assign empty      = status_i.empty;
   assign take       = pop && !status_i.empty;
   assign final_byte = (idx_ff == (head_i.count - 1'b1));
   assign out_last_o = head_i.last && final_byte;
   assign release_o  = take && final_byte;

   always_comb begin
      case (idx_ff)
         2'd0:    out_byte_o = head_i.data[0];
         2'd1:    out_byte_o = head_i.data[1];
         2'd2:    out_byte_o = head_i.data[2];
         default: out_byte_o = head_i.data[0];
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = final_byte ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !status_i.empty |-> (idx_ff < head_i.count))
      else $error("byte index beyond command length");

endmodule

/* design/quoted_printable_decoder_top.sv */
// ----------------------------------------------------------------------------
// quoted_printable_decoder_top
// Streaming quoted-printable decoder, one encoded byte per transfer in.
//
// Input channel: push/full with req_in_byte and req_in_last; a transfer
// happens on a clock edge with push high and full low. Result channel:
// empty/pop with rsp_out_byte and rsp_out_last; the oldest result is shown
// while empty is low and leaves on an edge with pop high.
// Each input byte yields zero to three result bytes. A result is registered
// into the command queue by the input transfer that causes it. The input
// side takes one byte every cycle while full is low; the result side gives
// one byte per cycle while pop is high, so an input that causes three results
// holds the result side until all three have left. A four-entry command queue
// between the classifier and the output sequencer absorbs this; full rises
// only when the queue fills because the receiver stalls or falls behind.
// The APB port holds accept_lowercase_hex at addresses 0 to 3 (reset value 1);
// write it only while the block is idle.
// Reset clears the escape state and the queue; no bytes are held after it.
// ----------------------------------------------------------------------------
module quoted_printable_decoder_top
   import qpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QPD_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_in_byte,
   input  logic                          req_in_last,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_out_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [QPD_CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic                 lower_ff, lower_in;
   logic                 csr_hit;
   logic                 accept;
   logic                 front_push;
   logic                 back_release;
   qpd_cmd_type          front_cmd;
   qpd_cmd_type          queue_head;
   qpd_queue_status_type queue_status;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[QPD_CSR_ADDR_WIDTH-1] == QPD_CSR_IDX_LOWERCASE);
   assign prdata  = csr_hit ? {31'b0, lower_ff} : 32'b0;

   always_comb begin
      lower_in = lower_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         lower_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= 1'b1;
      end else begin
         lower_ff <= lower_in;
      end
   end

   assign full   = queue_status.full;
   assign accept = push && !full;

   qpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_i  (accept),
      .in_byte_i (req_in_byte),
      .in_last_i (req_in_last),
      .lower_i   (lower_ff),
      .push_o    (front_push),
      .cmd_o     (front_cmd)
   );

   qpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_i   (front_push),
      .cmd_i    (front_cmd),
      .pop_i    (back_release),
      .head_o   (queue_head),
      .status_o (queue_status)
   );

   qpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_i     (queue_head),
      .status_i   (queue_status),
      .pop        (pop),
      .empty      (empty),
      .out_byte_o (rsp_out_byte),
      .out_last_o (rsp_out_last),
      .release_o  (back_release)
   );

endmodule
